FILE: rtl/core/otpc_pkg.sv
// Shared types, constants and register map for the tunnel packet classifier.
package otpc_pkg;

	// Result kinds
	localparam logic [2:0] KIND_REJECT    = 3'd0;
	localparam logic [2:0] KIND_INIT      = 3'd1;
	localparam logic [2:0] KIND_RESP      = 3'd2;
	localparam logic [2:0] KIND_COOKIE    = 3'd3;
	localparam logic [2:0] KIND_TRANSPORT = 3'd4;

	// Register indexes
	localparam logic [2:0] REG_PAD_INIT        = 3'd0;
	localparam logic [2:0] REG_PAD_RESP        = 3'd1;
	localparam logic [2:0] REG_PAD_COOKIE      = 3'd2;
	localparam logic [2:0] REG_TRANSPORT_SETUP = 3'd3;
	localparam logic [2:0] REG_RANGE_INIT      = 3'd4;
	localparam logic [2:0] REG_RANGE_RESP      = 3'd5;
	localparam logic [2:0] REG_RANGE_COOKIE    = 3'd6;
	localparam logic [2:0] REG_RANGE_TRANSPORT = 3'd7;

	// Message sizes
	localparam logic [7:0]  INIT_SIZE      = 8'd148;
	localparam logic [7:0]  RESP_SIZE      = 8'd92;
	localparam logic [7:0]  COOKIE_SIZE    = 8'd64;
	localparam logic [5:0]  TRANSPORT_MIN  = 6'd32;
	localparam logic [31:0] TRANSPORT_TYPE = 32'd4;
	localparam logic [15:0] MIN_LEN        = 16'd4;

	// Register reset values
	localparam logic [63:0] RANGE_INIT_RST      = 64'h0000_0001_0000_0001;
	localparam logic [63:0] RANGE_RESP_RST      = 64'h0000_0002_0000_0002;
	localparam logic [63:0] RANGE_COOKIE_RST    = 64'h0000_0003_0000_0003;
	localparam logic [63:0] RANGE_TRANSPORT_RST = 64'h0000_0004_0000_0004;

	typedef struct packed {
		logic [10:0] pad_init;
		logic [10:0] pad_resp;
		logic [10:0] pad_cookie;
		logic [9:0]  transport_setup;
		logic [63:0] range_init;
		logic [63:0] range_resp;
		logic [63:0] range_cookie;
		logic [63:0] range_transport;
	} cfg_t;

	typedef struct packed {
		logic [15:0] pkt_len;
		logic [31:0] word_at_start;
		logic [31:0] word_at_init_pad;
		logic [31:0] word_at_resp_pad;
		logic [31:0] word_at_cookie_pad;
		logic [31:0] word_at_transport_pad;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [10:0] payload_offset;
		logic [15:0] payload_len;
	} res_t;

endpackage

FILE: rtl/core/otpc_classify.sv
// Combinational classification of one registered request.
module otpc_classify (
	input  otpc_pkg::cfg_t cfg,
	input  otpc_pkg::req_t req,
	output otpc_pkg::res_t res
);

	logic [8:0]  tpad;
	logic        trailers;
	logic [16:0] len_x;
	logic [16:0] tot_init;
	logic [16:0] tot_resp;
	logic [16:0] tot_cookie;
	logic [16:0] tot_transport;
	logic        fit_init;
	logic        fit_resp;
	logic        fit_cookie;
	logic        fit_transport;
	logic        rng_init;
	logic        rng_resp;
	logic        rng_cookie;
	logic        rng_transport;
	logic        identity;

	assign tpad     = cfg.transport_setup[8:0];
	assign trailers = cfg.transport_setup[9];
	assign len_x    = {1'b0, req.pkt_len};

	// Expected totals per kind
	assign tot_init      = 17'(cfg.pad_init) + 17'(otpc_pkg::INIT_SIZE);
	assign tot_resp      = 17'(cfg.pad_resp) + 17'(otpc_pkg::RESP_SIZE);
	assign tot_cookie    = 17'(cfg.pad_cookie) + 17'(otpc_pkg::COOKIE_SIZE);
	assign tot_transport = 17'(tpad) + 17'(otpc_pkg::TRANSPORT_MIN);

	// Length checks; trailers allow longer datagrams
	assign fit_init      = (len_x == tot_init) || (trailers && len_x > tot_init);
	assign fit_resp      = (len_x == tot_resp) || (trailers && len_x > tot_resp);
	assign fit_cookie    = (len_x == tot_cookie) || (trailers && len_x > tot_cookie);
	assign fit_transport = len_x >= tot_transport;

	// Type word range checks, both bounds inclusive
	assign rng_init = req.word_at_init_pad >= cfg.range_init[31:0] &&
		req.word_at_init_pad <= cfg.range_init[63:32];
	assign rng_resp = req.word_at_resp_pad >= cfg.range_resp[31:0] &&
		req.word_at_resp_pad <= cfg.range_resp[63:32];
	assign rng_cookie = req.word_at_cookie_pad >= cfg.range_cookie[31:0] &&
		req.word_at_cookie_pad <= cfg.range_cookie[63:32];
	assign rng_transport = req.word_at_transport_pad >= cfg.range_transport[31:0] &&
		req.word_at_transport_pad <= cfg.range_transport[63:32];

	// Fast path: plain transport with no obfuscation configured
	assign identity = cfg.range_transport[31:0] == otpc_pkg::TRANSPORT_TYPE &&
		cfg.range_transport[63:32] == otpc_pkg::TRANSPORT_TYPE && tpad == 9'd0 &&
		req.word_at_start == otpc_pkg::TRANSPORT_TYPE &&
		req.pkt_len >= 16'(otpc_pkg::TRANSPORT_MIN);

	// Priority decision
	always_comb begin
		res = '0;
		if (req.pkt_len < otpc_pkg::MIN_LEN) begin
			res.kind = otpc_pkg::KIND_REJECT;
		end else if (identity) begin
			res.kind        = otpc_pkg::KIND_TRANSPORT;
			res.payload_len = req.pkt_len;
		end else if (fit_init && rng_init) begin
			res.kind           = otpc_pkg::KIND_INIT;
			res.payload_offset = cfg.pad_init;
			res.payload_len    = 16'(otpc_pkg::INIT_SIZE);
		end else if (fit_resp && rng_resp) begin
			res.kind           = otpc_pkg::KIND_RESP;
			res.payload_offset = cfg.pad_resp;
			res.payload_len    = 16'(otpc_pkg::RESP_SIZE);
		end else if (fit_cookie && rng_cookie) begin
			res.kind           = otpc_pkg::KIND_COOKIE;
			res.payload_offset = cfg.pad_cookie;
			res.payload_len    = 16'(otpc_pkg::COOKIE_SIZE);
		end else if (fit_transport && rng_transport) begin
			res.kind           = otpc_pkg::KIND_TRANSPORT;
			res.payload_offset = 11'(tpad);
			res.payload_len    = req.pkt_len - 16'(tpad);
		end
	end

endmodule

FILE: rtl/core/obfuscated_tunnel_packet_classifier_top.sv
// Top level of the tunnel packet classifier: config registers, input and result stages.
//
//  Channel   Signals                                         Direction  Handshake
//  request   start, busy, pkt_len, word_at_*                 in         start & !busy
//  result    done, kind, payload_offset, payload_len         out        done, one cycle
//  config    wr_en, wr_index, wr_data                        in         wr_en
//
// One request is taken per cycle and busy is never raised; classification is a single
// pass of logic between the input register and the result register.
// A taken request passes the input register and then the result register; done rises as
// the result register is loaded, and the receiver takes the result while done is high.
// Reset clears the valid flags and loads the register reset values.
// The receiver cannot stall; each result is shown for exactly one cycle.
module obfuscated_tunnel_packet_classifier_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] pkt_len,
	input  logic [31:0] word_at_start,
	input  logic [31:0] word_at_init_pad,
	input  logic [31:0] word_at_resp_pad,
	input  logic [31:0] word_at_cookie_pad,
	input  logic [31:0] word_at_transport_pad,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [63:0] wr_data,
	output logic        done,
	output logic [2:0]  kind,
	output logic [10:0] payload_offset,
	output logic [15:0] payload_len
);

	otpc_pkg::cfg_t cfg_q;
	otpc_pkg::req_t req_s1;
	otpc_pkg::res_t res_comb;
	otpc_pkg::res_t res_q;
	logic           valid_s1;
	logic           done_q;
	logic           accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pad_init        <= '0;
			cfg_q.pad_resp        <= '0;
			cfg_q.pad_cookie      <= '0;
			cfg_q.transport_setup <= '0;
			cfg_q.range_init      <= otpc_pkg::RANGE_INIT_RST;
			cfg_q.range_resp      <= otpc_pkg::RANGE_RESP_RST;
			cfg_q.range_cookie    <= otpc_pkg::RANGE_COOKIE_RST;
			cfg_q.range_transport <= otpc_pkg::RANGE_TRANSPORT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				otpc_pkg::REG_PAD_INIT:        cfg_q.pad_init        <= wr_data[10:0];
				otpc_pkg::REG_PAD_RESP:        cfg_q.pad_resp        <= wr_data[10:0];
				otpc_pkg::REG_PAD_COOKIE:      cfg_q.pad_cookie      <= wr_data[10:0];
				otpc_pkg::REG_TRANSPORT_SETUP: cfg_q.transport_setup <= wr_data[9:0];
				otpc_pkg::REG_RANGE_INIT:      cfg_q.range_init      <= wr_data;
				otpc_pkg::REG_RANGE_RESP:      cfg_q.range_resp      <= wr_data;
				otpc_pkg::REG_RANGE_COOKIE:    cfg_q.range_cookie    <= wr_data;
				otpc_pkg::REG_RANGE_TRANSPORT: cfg_q.range_transport <= wr_data;
				default: ;
			endcase
		end
	end

	// Input stage: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Input stage: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.pkt_len               <= pkt_len;
			req_s1.word_at_start         <= word_at_start;
			req_s1.word_at_init_pad      <= word_at_init_pad;
			req_s1.word_at_resp_pad      <= word_at_resp_pad;
			req_s1.word_at_cookie_pad    <= word_at_cookie_pad;
			req_s1.word_at_transport_pad <= word_at_transport_pad;
		end
	end

	otpc_classify u_classify (
		.cfg (cfg_q),
		.req (req_s1),
		.res (res_comb)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= res_comb;
		end
	end

	assign done           = done_q;
	assign kind           = res_q.kind;
	assign payload_offset = res_q.payload_offset;
	assign payload_len    = res_q.payload_len;

	// Every taken request yields one result
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("request without result");

	// A rejected request carries no offset and no length
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind == otpc_pkg::KIND_REJECT |-> payload_offset == 11'd0 &&
		payload_len == 16'd0)
		else $error("reject with nonzero payload fields");

	// Transport payload is never shorter than the minimum message
	a_transport_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind == otpc_pkg::KIND_TRANSPORT |->
		payload_len >= 16'(otpc_pkg::TRANSPORT_MIN))
		else $error("transport payload too short");

	// Initiation results report their fixed message size
	a_init_size: assert property (@(posedge clk) disable iff (!arst_n)
		done && kind == otpc_pkg::KIND_INIT |-> payload_len == 16'(otpc_pkg::INIT_SIZE))
		else $error("initiation size mismatch");

endmodule
